@@ design/assert_macros.svh @@
// assertion helpers, clocked on clock, off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SCT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/sctht_pkg.sv @@
package sctht_pkg;

   localparam int PHASE_W = 4;
   localparam int SIZE_W  = 33;

   localparam logic [PHASE_W-1:0] PH_CMD      = 4'd0;
   localparam logic [PHASE_W-1:0] PH_PARM     = 4'd1;
   localparam logic [PHASE_W-1:0] PH_STD_ACK  = 4'd2;
   localparam logic [PHASE_W-1:0] PH_EXT_ACK  = 4'd3;
   localparam logic [PHASE_W-1:0] PH_UNSUP    = 4'd4;
   localparam logic [PHASE_W-1:0] PH_LAST     = 4'd5;
   localparam logic [PHASE_W-1:0] PH_INFO     = 4'd6;
   localparam logic [PHASE_W-1:0] PH_GETPARM  = 4'd7;
   localparam logic [PHASE_W-1:0] PH_STD_NAK  = 4'd8;
   localparam logic [PHASE_W-1:0] PH_STD_DATA = 4'd9;
   localparam logic [PHASE_W-1:0] PH_STD_HDR  = 4'd10;
   localparam logic [PHASE_W-1:0] PH_EXT_NAK  = 4'd11;
   localparam logic [PHASE_W-1:0] PH_EXT_DATA = 4'd12;
   localparam logic [PHASE_W-1:0] PH_EXT_HDR  = 4'd13;

   localparam logic [7:0] BYTE_EOT = 8'h04;
   localparam logic [7:0] BYTE_ACK = 8'h06;
   localparam logic [7:0] BYTE_FF  = 8'h0C;
   localparam logic [7:0] BYTE_NAK = 8'h15;
   localparam logic [7:0] BYTE_CAN = 8'h18;
   localparam logic [7:0] BYTE_PF  = 8'h19;
   localparam logic [7:0] BYTE_ESC = 8'h1B;
   localparam logic [7:0] BYTE_FS  = 8'h1C;
   localparam logic [7:0] END_CODE_MASK = 8'h20;

   localparam logic [7:0] CH_LO_D = 8'h64;

   typedef struct packed {
      logic        req_type;
      logic [15:0] msg_length;
      logic [7:0]  first_byte;
      logic [7:0]  second_byte;
      logic [31:0] dword_two;
      logic [31:0] dword_six;
      logic [31:0] dword_ten;
      logic [7:0]  final_byte;
   } req_word_type;

   typedef struct packed {
      logic               accepted;
      logic               forward_to_device;
      logic [SIZE_W-1:0]  read_length;
      logic               self_nak;
      logic [SIZE_W-1:0]  next_read_length;
      logic               host_turn;
      logic [PHASE_W-1:0] phase_out;
   } rsp_word_type;

   typedef struct packed {
      logic               found;
      logic [PHASE_W-1:0] phase;
      logic [6:0]         size;
   } lookup_type;

endpackage

@@ design/sctht_cmd_lookup.sv @@
module sctht_cmd_lookup (
   input  logic [15:0]          msg_length,
   input  logic [7:0]           first_byte,
   input  logic [7:0]           second_byte,
   output sctht_pkg::lookup_type lookup
);
   import sctht_pkg::*;

   localparam logic [7:0] CH_EXCL = 8'h21;
   localparam logic [7:0] CH_LPAR = 8'h28;
   localparam logic [7:0] CH_RPAR = 8'h29;
   localparam logic [7:0] CH_AT   = 8'h40;
   localparam logic [7:0] CH_UP_A = 8'h41;
   localparam logic [7:0] CH_UP_B = 8'h42;
   localparam logic [7:0] CH_UP_C = 8'h43;
   localparam logic [7:0] CH_UP_D = 8'h44;
   localparam logic [7:0] CH_UP_F = 8'h46;
   localparam logic [7:0] CH_UP_G = 8'h47;
   localparam logic [7:0] CH_UP_H = 8'h48;
   localparam logic [7:0] CH_UP_I = 8'h49;
   localparam logic [7:0] CH_UP_K = 8'h4B;
   localparam logic [7:0] CH_UP_L = 8'h4C;
   localparam logic [7:0] CH_UP_M = 8'h4D;
   localparam logic [7:0] CH_UP_N = 8'h4E;
   localparam logic [7:0] CH_UP_P = 8'h50;
   localparam logic [7:0] CH_UP_Q = 8'h51;
   localparam logic [7:0] CH_UP_R = 8'h52;
   localparam logic [7:0] CH_UP_S = 8'h53;
   localparam logic [7:0] CH_UP_W = 8'h57;
   localparam logic [7:0] CH_UP_X = 8'h58;
   localparam logic [7:0] CH_UP_Y = 8'h59;
   localparam logic [7:0] CH_UP_Z = 8'h5A;
   localparam logic [7:0] CH_LBRK = 8'h5B;
   localparam logic [7:0] CH_RBRK = 8'h5D;
   localparam logic [7:0] CH_LO_B = 8'h62;
   localparam logic [7:0] CH_LO_E = 8'h65;
   localparam logic [7:0] CH_LO_F = 8'h66;
   localparam logic [7:0] CH_LO_G = 8'h67;
   localparam logic [7:0] CH_LO_I = 8'h69;
   localparam logic [7:0] CH_LO_M = 8'h6D;
   localparam logic [7:0] CH_LO_P = 8'h70;
   localparam logic [7:0] CH_LO_Q = 8'h71;
   localparam logic [7:0] CH_LO_S = 8'h73;
   localparam logic [7:0] CH_LO_T = 8'h74;
   localparam logic [7:0] CH_LO_W = 8'h77;
   localparam logic [7:0] CH_LO_Z = 8'h7A;

   lookup_type esc_hit;
   lookup_type fs_hit;

   always_comb begin
      esc_hit = '{found: 1'b1, phase: PH_LAST, size: 7'd1};
      case (second_byte)
         CH_EXCL, CH_UP_I, CH_UP_S, CH_LO_F, CH_LO_I, CH_LO_Q: begin
            esc_hit.phase = PH_INFO;
            esc_hit.size  = 7'd4;
         end
         CH_AT, CH_LO_W: esc_hit.phase = PH_LAST;
         CH_UP_F: esc_hit.size = 7'd4;
         CH_UP_G: begin
            esc_hit.phase = PH_STD_HDR;
            esc_hit.size  = 7'd4;
         end
         CH_UP_A, CH_UP_C, CH_UP_D, CH_UP_N, CH_UP_R, CH_UP_Z,
         CH_LO_D, CH_LO_E, CH_LO_G, CH_LO_T, CH_LO_Z:
            esc_hit.phase = PH_GETPARM;
         CH_LPAR, CH_RPAR, CH_UP_B, CH_UP_H, CH_UP_K, CH_UP_L,
         CH_UP_M, CH_UP_P, CH_UP_Q, CH_LBRK, CH_RBRK, CH_LO_B,
         CH_LO_M, CH_LO_P, CH_LO_S:
            esc_hit.phase = PH_UNSUP;
         default: esc_hit.found = 1'b0;
      endcase
   end

   always_comb begin
      fs_hit = '{found: 1'b1, phase: PH_LAST, size: 7'd1};
      case (second_byte)
         CH_UP_F: fs_hit.size = 7'd16;
         CH_UP_G: begin
            fs_hit.phase = PH_EXT_HDR;
            fs_hit.size  = 7'd14;
         end
         CH_UP_I: fs_hit.size = 7'd80;
         CH_UP_S: fs_hit.size = 7'd64;
         CH_UP_W: fs_hit.phase = PH_GETPARM;
         CH_UP_X, CH_UP_Y: fs_hit.phase = PH_UNSUP;
         default: fs_hit.found = 1'b0;
      endcase
   end

   always_comb begin
      lookup = '{found: 1'b0, phase: PH_UNSUP, size: 7'd1};
      if (msg_length == 16'd1) begin
         if (first_byte == BYTE_CAN || first_byte == BYTE_EOT ||
             first_byte == BYTE_FF || first_byte == BYTE_PF) begin
            lookup = '{found: 1'b1, phase: PH_LAST, size: 7'd1};
         end
      end else if (msg_length == 16'd2) begin
         if (first_byte == BYTE_ESC) begin
            lookup = esc_hit;
         end else if (first_byte == BYTE_FS) begin
            lookup = fs_hit;
         end
      end
   end

endmodule

@@ design/sctht_core.sv @@
module sctht_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  sctht_pkg::req_word_type word,
   output sctht_pkg::rsp_word_type result
);
   import sctht_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [SIZE_W-1:0]  pending_ff, pending_in;
   logic [7:0]         lines_ff, lines_in;
   logic               sets_lines_ff, sets_lines_in;
   logic [SIZE_W-1:0]  blk_size_ff, blk_size_in;
   logic [31:0]        blk_left_ff, blk_left_in;
   logic [SIZE_W-1:0]  last_size_ff, last_size_in;
   logic               end_code_ff, end_code_in;

   lookup_type  lookup;
   logic        host_now;
   logic        ext_ack;
   logic        len_nz;
   logic [15:0] mul_a;
   logic [31:0] product;
   logic        accepted, fwd, nak;
   logic [SIZE_W-1:0] rd;

   sctht_cmd_lookup u_lookup (
      .msg_length (word.msg_length),
      .first_byte (word.first_byte),
      .second_byte(word.second_byte),
      .lookup     (lookup)
   );

   assign host_now = (phase_ff <= PH_EXT_ACK);
   assign ext_ack  = (phase_ff == PH_EXT_ACK);
   assign len_nz   = (word.msg_length != 16'd0);
   assign mul_a    = (lines_ff != 8'd0) ? word.dword_two[31:16] : 16'd1;
   assign product  = 32'(mul_a) * 32'(word.dword_two[15:0]);

   always_comb begin
      phase_in      = phase_ff;
      pending_in    = pending_ff;
      lines_in      = lines_ff;
      sets_lines_in = sets_lines_ff;
      blk_size_in   = blk_size_ff;
      blk_left_in   = blk_left_ff;
      last_size_in  = last_size_ff;
      end_code_in   = end_code_ff;
      accepted      = 1'b0;
      fwd           = 1'b0;
      nak           = 1'b0;
      rd            = '0;
      if (host_now && !word.req_type) begin
         accepted = 1'b1;
         if (phase_ff == PH_CMD) begin
            if (lookup.found) begin
               phase_in      = lookup.phase;
               pending_in    = SIZE_W'(lookup.size);
               sets_lines_in = (word.msg_length == 16'd2) && (word.first_byte == BYTE_ESC) &&
                               (word.second_byte == CH_LO_D);
               fwd           = (lookup.phase != PH_UNSUP);
            end else begin
               phase_in      = PH_UNSUP;
               pending_in    = '0;
               sets_lines_in = 1'b0;
            end
         end else if (phase_ff == PH_PARM) begin
            fwd        = 1'b1;
            phase_in   = PH_LAST;
            pending_in = SIZE_W'(1);
            if (sets_lines_ff) begin
               lines_in = len_nz ? word.first_byte : 8'd0;
            end
         end else begin
            fwd        = 1'b1;
            pending_in = SIZE_W'(1);
            // an empty reply falls through to the NAK path
            if (len_nz && word.first_byte == BYTE_ACK) begin
               phase_in = ext_ack ? PH_EXT_DATA : PH_STD_HDR;
            end else if (len_nz && word.first_byte == BYTE_CAN) begin
               phase_in = PH_LAST;
            end else if (ext_ack && len_nz && word.first_byte == BYTE_EOT && end_code_ff) begin
               phase_in = PH_LAST;
            end else begin
               phase_in = ext_ack ? PH_EXT_NAK : PH_STD_NAK;
            end
         end
      end else if (!host_now && word.req_type) begin
         accepted = 1'b1;
         case (phase_ff)
            PH_UNSUP: begin
               nak      = 1'b1;
               phase_in = PH_CMD;
            end
            PH_STD_NAK: begin
               nak      = 1'b1;
               phase_in = PH_STD_ACK;
            end
            PH_EXT_NAK: begin
               nak      = 1'b1;
               phase_in = PH_EXT_ACK;
            end
            PH_LAST: begin
               rd       = pending_ff;
               phase_in = PH_CMD;
            end
            PH_INFO: begin
               rd         = pending_ff;
               pending_in = SIZE_W'(word.dword_two[15:0]);
               phase_in   = PH_LAST;
            end
            PH_GETPARM: begin
               rd       = pending_ff;
               phase_in = (word.first_byte != BYTE_NAK) ? PH_PARM : PH_CMD;
            end
            PH_STD_DATA: begin
               rd       = pending_ff;
               phase_in = PH_STD_ACK;
            end
            PH_STD_HDR: begin
               rd         = (lines_ff != 8'd0) ? SIZE_W'(6) : SIZE_W'(4);
               pending_in = SIZE_W'(product);
               phase_in   = PH_STD_DATA;
            end
            PH_EXT_HDR: begin
               rd           = pending_ff;
               blk_size_in  = SIZE_W'(word.dword_two) + SIZE_W'(1);
               blk_left_in  = word.dword_six;
               last_size_in = SIZE_W'(word.dword_ten) + SIZE_W'(1);
               phase_in     = PH_EXT_DATA;
            end
            default: begin
               if (blk_left_ff != 32'd0) begin
                  phase_in    = PH_EXT_ACK;
                  pending_in  = blk_size_ff;
                  blk_left_in = blk_left_ff - 32'd1;
               end else begin
                  phase_in   = PH_CMD;
                  pending_in = last_size_ff;
               end
               rd          = pending_in;
               end_code_in = ((word.final_byte & END_CODE_MASK) != 8'd0);
            end
         endcase
      end
   end

   always_comb begin
      result.accepted          = accepted;
      result.forward_to_device = fwd;
      result.read_length       = rd;
      result.self_nak          = nak;
      result.next_read_length  = pending_in;
      result.host_turn         = (phase_in <= PH_EXT_ACK);
      result.phase_out         = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_CMD;
         pending_ff    <= '0;
         lines_ff      <= '0;
         sets_lines_ff <= 1'b0;
         blk_size_ff   <= '0;
         blk_left_ff   <= '0;
         last_size_ff  <= '0;
         end_code_ff   <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         pending_ff    <= pending_in;
         lines_ff      <= lines_in;
         sets_lines_ff <= sets_lines_in;
         blk_size_ff   <= blk_size_in;
         blk_left_ff   <= blk_left_in;
         last_size_ff  <= last_size_in;
         end_code_ff   <= end_code_in;
      end
   end

endmodule

@@ design/scanner_command_handshake_tracker_unit.sv @@
// channel   direction  handshake               word
// req_      in         req_valid / req_stall   host message or device reply turn
// rsp_      out        rsp_valid / rsp_stall   forward, read sizes, turn, phase
//
// One word per cycle sustained while rsp_stall is low. A word accepted on req sits in
// the input register, is decoded combinationally against the tracker state and lands
// in the result register, which drives rsp_valid, as the state updates.
// Synchronous reset puts the tracker in the await-command phase, both registers empty.
// rsp_stall holds the result register; the input register then fills and req_stall rises.
module scanner_command_handshake_tracker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [15:0] req_msg_length,
   input  logic [7:0]  req_first_byte,
   input  logic [7:0]  req_second_byte,
   input  logic [31:0] req_reply_dword_at_two,
   input  logic [31:0] req_reply_dword_at_six,
   input  logic [31:0] req_reply_dword_at_ten,
   input  logic [7:0]  req_reply_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic        rsp_forward_to_device,
   output logic [32:0] rsp_read_length,
   output logic        rsp_self_nak,
   output logic [32:0] rsp_next_read_length,
   output logic        rsp_host_turn,
   output logic [3:0]  rsp_phase_out
);
   import sctht_pkg::*;

   `include "assert_macros.svh"

   logic         in_valid_ff, in_valid_in;
   logic         out_valid_ff, out_valid_in;
   req_word_type in_word_ff;
   rsp_word_type out_word_ff;
   rsp_word_type step_result;
   logic         advance;
   logic         step;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = step ? 1'b1 : (out_valid_ff && rsp_stall);

   sctht_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .word  (in_word_ff),
      .result(step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff.req_type    <= req_type;
         in_word_ff.msg_length  <= req_msg_length;
         in_word_ff.first_byte  <= req_first_byte;
         in_word_ff.second_byte <= req_second_byte;
         in_word_ff.dword_two   <= req_reply_dword_at_two;
         in_word_ff.dword_six   <= req_reply_dword_at_six;
         in_word_ff.dword_ten   <= req_reply_dword_at_ten;
         in_word_ff.final_byte  <= req_reply_final_byte;
      end
      if (step) begin
         out_word_ff <= step_result;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_accepted          = out_word_ff.accepted;
   assign rsp_forward_to_device = out_word_ff.forward_to_device;
   assign rsp_read_length       = out_word_ff.read_length;
   assign rsp_self_nak          = out_word_ff.self_nak;
   assign rsp_next_read_length  = out_word_ff.next_read_length;
   assign rsp_host_turn         = out_word_ff.host_turn;
   assign rsp_phase_out         = out_word_ff.phase_out;

   `SCT_ASSERT_NOW(a_ignored_is_quiet, rsp_valid && !rsp_accepted,
      !rsp_forward_to_device && !rsp_self_nak && rsp_read_length == 33'd0,
      "out-of-turn word produced activity")
   `SCT_ASSERT_NOW(a_nak_no_read, rsp_valid && rsp_self_nak,
      rsp_host_turn && rsp_read_length == 33'd0,
      "self NAK read the device or kept the device turn")
   `SCT_ASSERT_NOW(a_forward_hands_turn, rsp_valid && rsp_forward_to_device,
      !rsp_host_turn && rsp_accepted,
      "forwarded message left the turn with the host")
   `SCT_ASSERT_NEXT(a_stall_holds_input, req_stall, in_valid_ff,
      "input register lost a stalled word")

endmodule

@@ sim/sctht_scoreboard.sv @@
`timescale 1ns / 100ps

module sctht_scoreboard
   import sctht_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                req_type,
   input  logic [15:0]         req_msg_length,
   input  logic [7:0]          req_first_byte,
   input  logic [7:0]          req_second_byte,
   input  logic [31:0]         req_reply_dword_at_two,
   input  logic [31:0]         req_reply_dword_at_six,
   input  logic [31:0]         req_reply_dword_at_ten,
   input  logic [7:0]          req_reply_final_byte,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                rsp_accepted,
   input  logic                rsp_forward_to_device,
   input  logic [32:0]         rsp_read_length,
   input  logic                rsp_self_nak,
   input  logic [32:0]         rsp_next_read_length,
   input  logic                rsp_host_turn,
   input  logic [3:0]          rsp_phase_out,
   output int                  mismatch_count,
   output int                  checked_words,
   output int                  pending_words,
   output logic [PHASE_W-1:0]  phase_if_taken
);

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [SIZE_W-1:0]  pending;
      logic [7:0]         lines;
      logic               sets_lines;
      logic [SIZE_W-1:0]  blk_size;
      logic [31:0]        blocks_left;
      logic [SIZE_W-1:0]  last_size;
      logic               end_code;
   } tracker_state_type;

   typedef struct packed {
      tracker_state_type st;
      rsp_word_type      rsp;
   } tracker_step_type;

   tracker_state_type tracker_q;
   tracker_step_type  step_now;
   req_word_type      req_now;
   rsp_word_type      predicted_rsp_q[$];

   function automatic lookup_type decode_command(logic [15:0] len, logic [7:0] b0,
                                                 logic [7:0] b1);
      lookup_type d;
      d.found = 1'b1;
      d.phase = PH_UNSUP;
      d.size  = 7'd1;
      if (len == 16'd1) begin
         if (b0 == BYTE_CAN || b0 == BYTE_EOT || b0 == BYTE_FF || b0 == BYTE_PF)
            d.phase = PH_LAST;
         else
            d.found = 1'b0;
      end else if (len != 16'd2) begin
         d.found = 1'b0;
      end else if (b0 == BYTE_ESC) begin
         case (b1)
            "!", "I", "S", "f", "i", "q": begin
               d.phase = PH_INFO;
               d.size  = 7'd4;
            end
            "@", "w": d.phase = PH_LAST;
            "F": begin
               d.phase = PH_LAST;
               d.size  = 7'd4;
            end
            "G": begin
               d.phase = PH_STD_HDR;
               d.size  = 7'd4;
            end
            "A", "C", "D", "N", "R", "Z", "d", "e", "g", "t", "z": d.phase = PH_GETPARM;
            "(", ")", "B", "H", "K", "L", "M", "P", "Q", "[", "]", "b", "m", "p", "s":
               d.phase = PH_UNSUP;
            default: d.found = 1'b0;
         endcase
      end else if (b0 == BYTE_FS) begin
         case (b1)
            "F": begin
               d.phase = PH_LAST;
               d.size  = 7'd16;
            end
            "G": begin
               d.phase = PH_EXT_HDR;
               d.size  = 7'd14;
            end
            "I": begin
               d.phase = PH_LAST;
               d.size  = 7'd80;
            end
            "S": begin
               d.phase = PH_LAST;
               d.size  = 7'd64;
            end
            "W": d.phase = PH_GETPARM;
            "X", "Y": d.phase = PH_UNSUP;
            default: d.found = 1'b0;
         endcase
      end else begin
         d.found = 1'b0;
      end
      return d;
   endfunction

   function automatic tracker_step_type advance_tracker(tracker_state_type s, req_word_type w);
      tracker_step_type r;
      lookup_type       d;
      logic             host_now;
      logic             ext;
      logic [8:0]       rep;
      logic [15:0]      hdr_lines;
      r.st     = s;
      r.rsp    = '0;
      host_now = s.phase <= PH_EXT_ACK;
      ext      = s.phase == PH_EXT_ACK;
      if (host_now && !w.req_type) begin
         r.rsp.accepted = 1'b1;
         if (s.phase == PH_CMD) begin
            d = decode_command(w.msg_length, w.first_byte, w.second_byte);
            if (d.found) begin
               r.st.phase      = d.phase;
               r.st.pending    = SIZE_W'(d.size);
               r.st.sets_lines = w.msg_length == 16'd2 && w.first_byte == BYTE_ESC &&
                                 w.second_byte == CH_LO_D;
               r.rsp.forward_to_device = d.phase != PH_UNSUP;
            end else begin
               r.st.phase      = PH_UNSUP;
               r.st.pending    = '0;
               r.st.sets_lines = 1'b0;
            end
         end else if (s.phase == PH_PARM) begin
            r.rsp.forward_to_device = 1'b1;
            r.st.phase   = PH_LAST;
            r.st.pending = SIZE_W'(1);
            if (s.sets_lines)
               r.st.lines = (w.msg_length != 16'd0) ? w.first_byte : 8'd0;
         end else begin
            // empty acknowledgement falls through to NAK handling
            rep = (w.msg_length != 16'd0) ? {1'b0, w.first_byte} : 9'h100;
            r.rsp.forward_to_device = 1'b1;
            if (rep == {1'b0, BYTE_ACK})
               r.st.phase = ext ? PH_EXT_DATA : PH_STD_HDR;
            else if (rep == {1'b0, BYTE_CAN})
               r.st.phase = PH_LAST;
            else if (ext && rep == {1'b0, BYTE_EOT} && s.end_code)
               r.st.phase = PH_LAST;
            else
               r.st.phase = ext ? PH_EXT_NAK : PH_STD_NAK;
            r.st.pending = SIZE_W'(1);
         end
      end else if (!host_now && w.req_type) begin
         r.rsp.accepted = 1'b1;
         case (s.phase)
            PH_UNSUP: begin
               r.rsp.self_nak = 1'b1;
               r.st.phase     = PH_CMD;
            end
            PH_STD_NAK: begin
               r.rsp.self_nak = 1'b1;
               r.st.phase     = PH_STD_ACK;
            end
            PH_EXT_NAK: begin
               r.rsp.self_nak = 1'b1;
               r.st.phase     = PH_EXT_ACK;
            end
            PH_LAST: begin
               r.rsp.read_length = s.pending;
               r.st.phase        = PH_CMD;
            end
            PH_INFO: begin
               r.rsp.read_length = s.pending;
               r.st.pending      = SIZE_W'(w.dword_two[15:0]);
               r.st.phase        = PH_LAST;
            end
            PH_GETPARM: begin
               r.rsp.read_length = s.pending;
               r.st.phase        = (w.first_byte != BYTE_NAK) ? PH_PARM : PH_CMD;
            end
            PH_STD_DATA: begin
               r.rsp.read_length = s.pending;
               r.st.phase        = PH_STD_ACK;
            end
            PH_STD_HDR: begin
               r.rsp.read_length = (s.lines != 8'd0) ? SIZE_W'(6) : SIZE_W'(4);
               hdr_lines    = (s.lines != 8'd0) ? w.dword_two[31:16] : 16'd1;
               r.st.pending = SIZE_W'(hdr_lines) * SIZE_W'(w.dword_two[15:0]);
               r.st.phase   = PH_STD_DATA;
            end
            PH_EXT_HDR: begin
               r.rsp.read_length = s.pending;
               r.st.blk_size     = SIZE_W'(w.dword_two) + SIZE_W'(1);
               r.st.blocks_left  = w.dword_six;
               r.st.last_size    = SIZE_W'(w.dword_ten) + SIZE_W'(1);
               r.st.phase        = PH_EXT_DATA;
            end
            default: begin
               if (s.blocks_left != 32'd0) begin
                  r.st.phase       = PH_EXT_ACK;
                  r.st.pending     = s.blk_size;
                  r.st.blocks_left = s.blocks_left - 32'd1;
               end else begin
                  r.st.phase   = PH_CMD;
                  r.st.pending = s.last_size;
               end
               r.rsp.read_length = r.st.pending;
               r.st.end_code     = (w.final_byte & END_CODE_MASK) != 8'd0;
            end
         endcase
      end
      r.rsp.next_read_length = r.st.pending;
      r.rsp.host_turn        = r.st.phase <= PH_EXT_ACK;
      r.rsp.phase_out        = r.st.phase;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [32:0] got, logic [32:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   assign req_now = {req_type, req_msg_length, req_first_byte, req_second_byte,
                     req_reply_dword_at_two, req_reply_dword_at_six,
                     req_reply_dword_at_ten, req_reply_final_byte};

   always_comb step_now = advance_tracker(tracker_q, req_now);

   assign phase_if_taken = step_now.st.phase;

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         tracker_q <= '0;
         predicted_rsp_q.delete();
         pending_words  <= 0;
         mismatch_count = 0;
         checked_words  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp_q.size() == 0) begin
               report_mismatch("result word with nothing outstanding");
            end else begin
               want = predicted_rsp_q.pop_front();
               check_field("accepted", 33'(rsp_accepted), 33'(want.accepted));
               check_field("forward_to_device", 33'(rsp_forward_to_device),
                           33'(want.forward_to_device));
               check_field("read_length", rsp_read_length, want.read_length);
               check_field("self_nak", 33'(rsp_self_nak), 33'(want.self_nak));
               check_field("next_read_length", rsp_next_read_length, want.next_read_length);
               check_field("host_turn", 33'(rsp_host_turn), 33'(want.host_turn));
               check_field("phase_out", 33'(rsp_phase_out), 33'(want.phase_out));
               checked_words++;
            end
         end
         if (req_valid && !req_stall) begin
            tracker_q <= step_now.st;
            predicted_rsp_q.push_back(step_now.rsp);
         end
         pending_words <= predicted_rsp_q.size();
      end
   end

endmodule

@@ sim/tb_scanner_command_handshake_tracker_unit.sv @@
`timescale 1ns / 100ps

module tb_scanner_command_handshake_tracker_unit;
   import sctht_pkg::*;

   localparam int WORD_TOTAL = 650;
   localparam int IDLE_LIMIT = 4000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_type = 1'b0;
   logic [15:0]        req_msg_length = '0;
   logic [7:0]         req_first_byte = '0;
   logic [7:0]         req_second_byte = '0;
   logic [31:0]        req_reply_dword_at_two = '0;
   logic [31:0]        req_reply_dword_at_six = '0;
   logic [31:0]        req_reply_dword_at_ten = '0;
   logic [7:0]         req_reply_final_byte = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_accepted;
   logic               rsp_forward_to_device;
   logic [32:0]        rsp_read_length;
   logic               rsp_self_nak;
   logic [32:0]        rsp_next_read_length;
   logic               rsp_host_turn;
   logic [3:0]         rsp_phase_out;
   int                 mismatch_count;
   int                 checked_words;
   int                 pending_words;
   logic [PHASE_W-1:0] phase_if_taken;

   logic [PHASE_W-1:0] cur_phase = PH_CMD;
   int                 word_count = 0;
   int                 noise_count = 0;
   int                 burst_left = 0;
   int                 stall_mode = 0;
   int                 stall_left = 0;
   int                 idle_cycles = 0;

   scanner_command_handshake_tracker_unit u_top (.*);

   sctht_scoreboard u_scoreboard (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(10, 80);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= $urandom_range(0, 3) == 0;
         2: rsp_stall <= $urandom_range(0, 3) != 0;
         default: rsp_stall <= 1'($urandom_range(0, 1));
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_word(logic typ, logic [15:0] len, logic [7:0] b0, logic [7:0] b1,
                            logic [31:0] d2, logic [31:0] d6, logic [31:0] d10,
                            logic [7:0] fin);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 4) == 0) begin
            gap        = 0;
            burst_left = $urandom_range(40, 120);
         end else begin
            gap        = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 24);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid              <= 1'b1;
      req_type               <= typ;
      req_msg_length         <= len;
      req_first_byte         <= b0;
      req_second_byte        <= b1;
      req_reply_dword_at_two <= d2;
      req_reply_dword_at_six <= d6;
      req_reply_dword_at_ten <= d10;
      req_reply_final_byte   <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (typ == (cur_phase > PH_EXT_ACK))
         word_count++;
      else
         noise_count++;
      cur_phase = phase_if_taken;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   task automatic send_random_word();
      string       esc_letters = "!ISfiq@wFGACDNRZdegtz()BHKLMPQ[]bmps";
      string       fs_letters = "FGISWXY";
      logic        host_now;
      logic        typ;
      logic [15:0] len;
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  fin;
      logic [31:0] d2;
      logic [31:0] d6;
      logic [31:0] d10;
      int          pick;
      host_now = cur_phase <= PH_EXT_ACK;
      typ      = !host_now;
      len      = 16'($urandom);
      b0       = 8'($urandom);
      b1       = 8'($urandom);
      d2       = $urandom;
      d6       = $urandom;
      d10      = $urandom;
      fin      = 8'($urandom);
      if ($urandom_range(0, 99) < 8) begin
         typ = host_now;
      end else if (cur_phase == PH_CMD) begin
         pick = $urandom_range(0, 15);
         if (pick < 13)
            len = 16'd2;
         case (pick)
            0: begin
               len = 16'd1;
               case ($urandom_range(0, 3))
                  0: b0 = BYTE_CAN;
                  1: b0 = BYTE_EOT;
                  2: b0 = BYTE_FF;
                  default: b0 = BYTE_PF;
               endcase
            end
            1, 2, 3: begin
               b0 = BYTE_ESC;
               b1 = "G";
            end
            4, 5, 6: begin
               b0 = BYTE_FS;
               b1 = "G";
            end
            7: begin
               b0 = BYTE_ESC;
               b1 = CH_LO_D;
            end
            8, 9, 10: begin
               b0 = BYTE_ESC;
               b1 = esc_letters[$urandom_range(0, esc_letters.len() - 1)];
            end
            11: begin
               b0 = BYTE_FS;
               b1 = fs_letters[$urandom_range(0, fs_letters.len() - 1)];
            end
            12: ;
            13: len = 16'd1;
            default: if ($urandom_range(0, 1)) b0 = BYTE_ESC;
         endcase
      end else if (cur_phase == PH_PARM) begin
         len = ($urandom_range(0, 6) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
         if ($urandom_range(0, 2) == 0)
            b0 = 8'd0;
      end else if (host_now) begin
         len = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: b0 = BYTE_ACK;
            6: b0 = BYTE_CAN;
            7: b0 = BYTE_EOT;
            8: b0 = BYTE_NAK;
            default: ;
         endcase
      end else if (cur_phase == PH_EXT_HDR) begin
         if ($urandom_range(0, 9) != 0)
            d6 = $urandom_range(0, 3);
      end else if (cur_phase == PH_GETPARM) begin
         if ($urandom_range(0, 3) == 0)
            b0 = BYTE_NAK;
      end
      send_word(typ, len, b0, b1, d2, d6, d10, fin);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // info command, count at full width
      send_word(1'b0, 16'd2, BYTE_ESC, "!", '0, '0, '0, '0);
      send_word(1'b1, 16'd0, 8'd0, 8'd0, 32'hFFFF_FFFF, '0, '0, '0);
      send_word(1'b1, 16'd0, 8'd0, 8'd0, '0, '0, '0, '0);
      // line count parameter set to max
      send_word(1'b0, 16'd2, BYTE_ESC, CH_LO_D, '0, '0, '0, '0);
      send_word(1'b1, 16'd0, BYTE_ACK, 8'd0, '0, '0, '0, '0);
      send_word(1'b0, 16'd1, 8'hFF, 8'd0, '0, '0, '0, '0);
      send_word(1'b1, 16'd0, 8'd0, 8'd0, '0, '0, '0, '0);
      // standard image: largest block, empty ack, ACK, CAN
      send_word(1'b0, 16'd2, BYTE_ESC, "G", '0, '0, '0, '0);
      send_word(1'b1, 16'd0, 8'd0, 8'd0, 32'hFFFF_FFFF, '0, '0, '0);
      send_word(1'b1, 16'd0, 8'd0, 8'd0, '0, '0, '0, '0);
      send_word(1'b0, 16'd0, BYTE_ACK, 8'd0, '0, '0, '0, '0);
      send_word(1'b1, 16'd0, 8'd0, 8'd0, '0, '0, '0, '0);
      send_word(1'b0, 16'd1, BYTE_ACK, 8'd0, '0, '0, '0, '0);
      send_word(1'b1, 16'd0, 8'd0, 8'd0, '0, '0, '0, '0);
      send_word(1'b1, 16'd0, 8'd0, 8'd0, '0, '0, '0, '0);
      send_word(1'b0, 16'd1, BYTE_CAN, 8'd0, '0, '0, '0, '0);
      send_word(1'b1, 16'd0, 8'd0, 8'd0, '0, '0, '0, '0);
      // extended image: sizes carry past 32 bits, EOT after end code
      send_word(1'b0, 16'd2, BYTE_FS, "G", '0, '0, '0, '0);
      send_word(1'b1, 16'd0, 8'd0, 8'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, '0);
      send_word(1'b1, 16'd0, 8'd0, 8'd0, '0, '0, '0, END_CODE_MASK);
      send_word(1'b0, 16'd1, BYTE_EOT, 8'd0, '0, '0, '0, '0);
      send_word(1'b1, 16'd0, 8'd0, 8'd0, '0, '0, '0, '0);
      // unsupported, unknown length, out of turn
      send_word(1'b0, 16'd2, BYTE_ESC, "B", '0, '0, '0, '0);
      send_word(1'b1, 16'd0, 8'd0, 8'd0, '0, '0, '0, '0);
      send_word(1'b0, 16'hFFFF, BYTE_ESC, "G", '0, '0, '0, '0);
      send_word(1'b1, 16'd0, 8'd0, 8'd0, '0, '0, '0, '0);
      send_word(1'b1, 16'hFFFF, 8'hFF, 8'hFF, '1, '1, '1, 8'hFF);

      while (word_count < WORD_TOTAL) begin
         if (word_count == WORD_TOTAL / 2)
            drain_results();
         send_random_word();
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("summary: %0d in-turn and %0d out-of-turn request words driven,",
               word_count, noise_count);
      $display("         %0d result words compared, %0d mismatches", checked_words,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
